// ===== src/armor_plate_position_predictor_assert.svh =====
// Assertion macros for the armor plate position predictor
`ifndef ARMOR_PLATE_POSITION_PREDICTOR_ASSERT_SVH
`define ARMOR_PLATE_POSITION_PREDICTOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define APPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/appp_pkg.sv =====
// Shared types, constants and functions of the armor plate position predictor
`timescale 1ns / 1ps
package appp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int STG_W         = $clog2(ATAN_ENTRIES);

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic [1:0] {
    KIND_ROBOT   = 2'd0,
    KIND_OUTPOST = 2'd1,
    KIND_BASE    = 2'd2,
    KIND_SPARE   = 2'd3
  } kind_t;

  localparam logic [15:0] OUTPOST_STEP1 = 16'd21845;
  localparam logic [15:0] OUTPOST_STEP2 = 16'd43691;

  typedef struct packed {
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [17:0] cz;
    logic [15:0]        yaw;
    logic signed [12:0] radius;
    logic signed [12:0] dz;
    logic [1:0]         num;
    logic               last;
  } ctx_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [33:0] atan_f(input int idx);
    logic signed [33:0] v;
    unique case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // clamp to the 17-bit position range
  function automatic logic [16:0] sat17(input logic signed [18:0] v);
    logic [16:0] r;
    if (v < -19'sd65536) begin
      r = 17'h10000;
    end else if (v > 19'sd65535) begin
      r = 17'h0FFFF;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ===== src/appp_seq.sv =====
// Target holder, plate sequencer and center/yaw prediction stages
`timescale 1ns / 1ps
`include "armor_plate_position_predictor_assert.svh"
module appp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          predict_time,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [175:0]         in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 v_out,
  output appp_pkg::cordic_t    cd_out,
  output appp_pkg::ctx_t       ctx_out,
  input  logic                 en_dn
);

  logic         busy_r;
  logic [1:0]   k_r, kmax_r;
  logic [175:0] hold_r;
  logic [1:0]   kind_r;
  logic         en1, en2, issuing, last_k;

  logic                v1_r;
  logic signed [31:0]  pvx_r, pvy_r, pvz_r;
  logic signed [35:0]  prate_r;
  logic signed [16:0]  cx1_r, cy1_r, cz1_r;
  logic [15:0]         hd1_r;
  logic signed [12:0]  rad1_r, dz1_r;
  logic [1:0]          num1_r;
  logic                last1_r;

  logic                v2_r;
  appp_pkg::cordic_t   cd2_r;
  appp_pkg::ctx_t      ctx2_r;

  logic signed [16:0] pt_s;
  logic signed [12:0] sp, sq, sr;
  logic signed [12:0] rad_n, dz_n;
  logic [15:0]        step_n;

  logic signed [32:0] tx, ty, tz;
  logic signed [36:0] tr;
  logic [15:0]        yaw_n;

  assign en2     = !v2_r || en_dn;
  assign en1     = !v1_r || en2;
  assign issuing = busy_r && en1;
  assign last_k  = (k_r == kmax_r);
  assign in_tready = !busy_r || (issuing && last_k);

  assign pt_s = {1'b0, predict_time};
  assign sp = hold_r[143:131];
  assign sq = hold_r[156:144];
  assign sr = hold_r[169:157];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
      kmax_r <= 2'd0;
    end else if (in_tvalid && in_tready) begin
      busy_r <= 1'b1;
      k_r    <= 2'd0;
      unique case (appp_pkg::kind_t'(in_tuser))
        appp_pkg::KIND_BASE:    kmax_r <= 2'd0;
        appp_pkg::KIND_OUTPOST: kmax_r <= 2'd2;
        appp_pkg::KIND_ROBOT,
        appp_pkg::KIND_SPARE:   kmax_r <= 2'd3;
      endcase
    end else if (issuing) begin
      if (last_k) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= in_tdata;
      kind_r <= in_tuser;
    end
  end

  // per-plate radius, height offset and yaw step
  always_comb begin
    unique case (appp_pkg::kind_t'(kind_r))
      appp_pkg::KIND_BASE: begin
        rad_n  = 13'sd0;
        dz_n   = 13'sd0;
        step_n = 16'd0;
      end
      appp_pkg::KIND_OUTPOST: begin
        rad_n = sp;
        unique case (k_r)
          2'd1: begin
            dz_n   = sq;
            step_n = appp_pkg::OUTPOST_STEP1;
          end
          2'd2: begin
            dz_n   = sr;
            step_n = appp_pkg::OUTPOST_STEP2;
          end
          default: begin
            dz_n   = 13'sd0;
            step_n = 16'd0;
          end
        endcase
      end
      appp_pkg::KIND_ROBOT,
      appp_pkg::KIND_SPARE: begin
        rad_n  = k_r[0] ? sq : sp;
        dz_n   = k_r[0] ? sr : 13'sd0;
        step_n = {k_r, 14'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pvx_r   <= $signed(hold_r[81:67])   * pt_s;
      pvy_r   <= $signed(hold_r[96:82])   * pt_s;
      pvz_r   <= $signed(hold_r[111:97])  * pt_s;
      prate_r <= $signed(hold_r[130:112]) * pt_s;
      cx1_r   <= hold_r[16:0];
      cy1_r   <= hold_r[33:17];
      cz1_r   <= hold_r[50:34];
      hd1_r   <= hold_r[66:51] + step_n;
      rad1_r  <= rad_n;
      dz1_r   <= dz_n;
      num1_r  <= k_r;
      last1_r <= last_k;
    end
  end

  // round half up of product / 65536
  always_comb begin
    tx = 33'(pvx_r) + 33'sd32768;
    ty = 33'(pvy_r) + 33'sd32768;
    tz = 33'(pvz_r) + 33'sd32768;
    tr = 37'(prate_r) + 37'sd32768;
    yaw_n = hd1_r + tr[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctx2_r.cx     <= 18'(cx1_r) + 18'($signed(tx[32:16]));
      ctx2_r.cy     <= 18'(cy1_r) + 18'($signed(ty[32:16]));
      ctx2_r.cz     <= 18'(cz1_r) + 18'($signed(tz[32:16]));
      ctx2_r.yaw    <= yaw_n;
      ctx2_r.radius <= rad1_r;
      ctx2_r.dz     <= dz1_r;
      ctx2_r.num    <= num1_r;
      ctx2_r.last   <= last1_r;
      cd2_r.x       <= appp_pkg::GAIN_Q30;
      cd2_r.y       <= 34'sd0;
      cd2_r.z       <= $signed({4'd0, yaw_n[13:0], 16'd0});
    end
  end

  assign v_out   = v2_r;
  assign cd_out  = cd2_r;
  assign ctx_out = ctx2_r;

  `APPP_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, busy_r && k_r == 2'd0, "target not loaded")
  `APPP_ASSERT_NOW(a_k_bound, busy_r, k_r <= kmax_r, "plate index past last plate")
  `APPP_ASSERT_NEXT(a_keep_busy, issuing && !last_k, busy_r, "target dropped before last plate")

endmodule

// ===== src/appp_cell.sv =====
// One CORDIC rotation cell of the sine/cosine chain
`timescale 1ns / 1ps
module appp_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [appp_pkg::STG_W-1:0]   shift_amt,
  input  logic signed [33:0]           atan_val,
  input  logic                         v_in,
  input  appp_pkg::cordic_t            cd_in,
  input  appp_pkg::ctx_t               ctx_in,
  output logic                         en_up,
  input  logic                         en_dn,
  output logic                         v_out,
  output appp_pkg::cordic_t            cd_out,
  output appp_pkg::ctx_t               ctx_out
);

  logic              v_r;
  appp_pkg::cordic_t cd_r;
  appp_pkg::ctx_t    ctx_r;
  logic signed [33:0] xi, yi, zi, xn, yn, zn;

  assign en_up = !v_r || en_dn;

  always_comb begin
    xi = cd_in.x;
    yi = cd_in.y;
    zi = cd_in.z;
    if (zi >= 34'sd0) begin
      xn = xi - (yi >>> shift_amt);
      yn = yi + (xi >>> shift_amt);
      zn = zi - atan_val;
    end else begin
      xn = xi + (yi >>> shift_amt);
      yn = yi - (xi >>> shift_amt);
      zn = zi + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_up) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      cd_r.x <= xn;
      cd_r.y <= yn;
      cd_r.z <= zn;
      ctx_r  <= ctx_in;
    end
  end

  assign v_out   = v_r;
  assign cd_out  = cd_r;
  assign ctx_out = ctx_r;

endmodule

// ===== src/appp_plate.sv =====
// Quadrant fold, radius scaling, saturation and output register
`timescale 1ns / 1ps
module appp_plate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_in,
  input  appp_pkg::cordic_t cd_in,
  input  appp_pkg::ctx_t    ctx_in,
  output logic              en_up,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,
  output logic              out_tlast
);

  logic               vq_r, vm_r, out_valid_r;
  logic               enq, enm, eno;
  logic signed [16:0] c_r, s_r;
  appp_pkg::ctx_t     ctxq_r, ctxm_r;
  logic signed [29:0] px_r, py_r;
  logic [16:0]        ox_r, oy_r, oz_r;
  logic [15:0]        ohd_r;
  logic [1:0]         onum_r;
  logic               olast_r;

  logic signed [33:0] xr, yr;
  logic signed [16:0] cc, ss, c_n, s_n;
  logic signed [30:0] rx, ry;
  logic signed [18:0] xo, yo, zo;

  assign eno   = !out_valid_r || out_tready;
  assign enm   = !vm_r || eno;
  assign enq   = !vq_r || enm;
  assign en_up = enq;

  // round to Q1.15 and clamp
  always_comb begin
    xr = cd_in.x + 34'sd16384;
    yr = cd_in.y + 34'sd16384;
    if ($signed(xr[33:15]) > 19'sd32767) begin
      cc = 17'sd32767;
    end else if ($signed(xr[33:15]) < -19'sd32768) begin
      cc = -17'sd32768;
    end else begin
      cc = 17'($signed(xr[33:15]));
    end
    if ($signed(yr[33:15]) > 19'sd32767) begin
      ss = 17'sd32767;
    end else if ($signed(yr[33:15]) < -19'sd32768) begin
      ss = -17'sd32768;
    end else begin
      ss = 17'($signed(yr[33:15]));
    end
    unique case (ctx_in.yaw[15:14])
      2'd0: begin c_n = cc;  s_n = ss;  end
      2'd1: begin c_n = -ss; s_n = cc;  end
      2'd2: begin c_n = -cc; s_n = -ss; end
      2'd3: begin c_n = ss;  s_n = -cc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r        <= 1'b0;
      vm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (enq) vq_r <= v_in;
      if (enm) vm_r <= vq_r;
      if (eno) out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      c_r    <= c_n;
      s_r    <= s_n;
      ctxq_r <= ctx_in;
    end
    if (enm) begin
      px_r   <= ctxq_r.radius * c_r;
      py_r   <= ctxq_r.radius * s_r;
      ctxm_r <= ctxq_r;
    end
  end

  always_comb begin
    rx = 31'(px_r) + 31'sd16384;
    ry = 31'(py_r) + 31'sd16384;
    xo = 19'(ctxm_r.cx) - 19'($signed(rx[30:15]));
    yo = 19'(ctxm_r.cy) - 19'($signed(ry[30:15]));
    zo = 19'(ctxm_r.cz) + 19'(ctxm_r.dz);
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      ox_r    <= appp_pkg::sat17(xo);
      oy_r    <= appp_pkg::sat17(yo);
      oz_r    <= appp_pkg::sat17(zo);
      ohd_r   <= ctxm_r.yaw;
      onum_r  <= ctxm_r.num;
      olast_r <= ctxm_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, onum_r, ohd_r, oz_r, oy_r, ox_r};
  assign out_tlast  = olast_r;

endmodule

// ===== src/armor_plate_position_predictor.sv =====
// Armor plate position predictor: top level
// One input word per target; the block emits 1 (base), 3 (outpost) or 4 (robot) plate words,
// one per cycle while the output does not stall; a new target is taken only as the last plate
// word of the current one issues. The sequencer holding the target sets that rate. From
// accept to first plate word the path runs through two prediction stages, one CORDIC cell per
// stage, quadrant fold, radius multiply and the output register. Predict time is taken from
// cfg_wdata when cfg_we is high.
`timescale 1ns / 1ps
module armor_plate_position_predictor (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, center_heading, vel_x, vel_y, vel_z, heading_rate,
  // shape_p, shape_q, shape_r, 6 bits zero
  input  logic [175:0] in_tdata,
  // target_kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // plate_x, plate_y, plate_z, plate_heading, plate_number, 3 bits zero
  output logic [71:0]  out_tdata,
  // last_plate
  output logic         out_tlast
);

  localparam int N = appp_pkg::CORDIC_STAGES;

  logic [15:0] predict_time_r;

  logic              en [N+1];
  logic              vv [N+1];
  appp_pkg::cordic_t cd [N+1];
  appp_pkg::ctx_t    cx [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predict_time_r <= 16'd0;
    end else if (cfg_we) begin
      predict_time_r <= cfg_wdata;
    end
  end

  appp_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .predict_time (predict_time_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .v_out        (vv[0]),
    .cd_out       (cd[0]),
    .ctx_out      (cx[0]),
    .en_dn        (en[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    appp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_amt (appp_pkg::STG_W'(i)),
      .atan_val  (appp_pkg::atan_f(i)),
      .v_in      (vv[i]),
      .cd_in     (cd[i]),
      .ctx_in    (cx[i]),
      .en_up     (en[i]),
      .en_dn     (en[i+1]),
      .v_out     (vv[i+1]),
      .cd_out    (cd[i+1]),
      .ctx_out   (cx[i+1])
    );
  end

  appp_plate u_plate (
    .clk        (clk),
    .rst_n      (rst_n),
    .v_in       (vv[N]),
    .cd_in      (cd[N]),
    .ctx_in     (cx[N]),
    .en_up      (en[N]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
